### rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Touch sampler package
// Shared types, register map and reset values for the calibrated touch sampler.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned SampleSlotsDefault = 8;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [RegIdxW-1:0] REG_GAIN_XX  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAIN_XY  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [RegIdxW-1:0] REG_GAIN_YX  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_GAIN_YY  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [RegIdxW-1:0] REG_INTERVAL = 3'd6;

  localparam logic signed [23:0] GainXxRst   = -24'sd979;
  localparam logic signed [23:0] GainXyRst   = -24'sd66777;
  localparam logic signed [19:0] OffsetXRst  = 20'sd64088;
  localparam logic signed [23:0] GainYxRst   = -24'sd93299;
  localparam logic signed [23:0] GainYyRst   = -24'sd1238;
  localparam logic signed [19:0] OffsetYRst  = 20'sd91274;
  localparam logic [7:0]         IntervalRst = 8'd10;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_PRE      = 2'd1;
  localparam logic [1:0] MODE_TOUCHED  = 2'd2;
  localparam logic [1:0] MODE_RELEASED = 2'd3;

  typedef struct packed {
    logic signed [23:0] gain_xx;
    logic signed [23:0] gain_xy;
    logic signed [19:0] offset_x;
    logic signed [23:0] gain_yx;
    logic signed [23:0] gain_yy;
    logic signed [19:0] offset_y;
  } cal_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        valid;
    logic [2:0]  slot;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
  } tick_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       valid;
    logic [2:0] slot;
    logic [9:0] point_x;
    logic [9:0] point_y;
  } result_t;

endpackage

### rtl/touch_sampler_calibrated.sv
// ----------------------------------------------------------------------------
// Calibrated touch sampler
// Tick-driven touch panel sampler with affine screen calibration.
// ----------------------------------------------------------------------------
// An accepted tick word passes the tick queue, the multiply stage and the result queue.
// Throughput: one tick word per cycle while the tick queue is not full, set by the pipelined multiply stage.
// Reset: mode idle, counter and slot cleared, registers at calibration defaults.
module touch_sampler_calibrated #(
  parameter int unsigned SAMPLE_SLOTS = tsc_pkg::SampleSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsc_pkg::AddrWidth-1:0]  paddr,
  input  logic [tsc_pkg::DataWidth-1:0]  pwdata,
  output logic [tsc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  input  logic                           push,
  output logic                           full,
  input  logic                           pen_down_i,
  input  logic [11:0]                    raw_x_i,
  input  logic [11:0]                    raw_y_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     mode_o,
  output logic                           sample_valid_o,
  output logic [2:0]                     sample_slot_o,
  output logic [9:0]                     point_x_o,
  output logic [9:0]                     point_y_o
);

  import tsc_pkg::*;

  cal_t               cal_q;
  logic [7:0]         interval_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;
  logic               accept;
  tick_t              front_tick, mid_tick;
  logic               mid_full, mid_empty, mid_pop;
  logic               out_full, out_push;
  result_t            back_res, out_res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.gain_xx  <= GainXxRst;
      cal_q.gain_xy  <= GainXyRst;
      cal_q.offset_x <= OffsetXRst;
      cal_q.gain_yx  <= GainYxRst;
      cal_q.gain_yy  <= GainYyRst;
      cal_q.offset_y <= OffsetYRst;
      interval_q     <= IntervalRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_XX:  cal_q.gain_xx  <= pwdata[23:0];
        REG_GAIN_XY:  cal_q.gain_xy  <= pwdata[23:0];
        REG_OFFSET_X: cal_q.offset_x <= pwdata[19:0];
        REG_GAIN_YX:  cal_q.gain_yx  <= pwdata[23:0];
        REG_GAIN_YY:  cal_q.gain_yy  <= pwdata[23:0];
        REG_OFFSET_Y: cal_q.offset_y <= pwdata[19:0];
        REG_INTERVAL: interval_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_XX:  prdata = {8'd0, cal_q.gain_xx};
      REG_GAIN_XY:  prdata = {8'd0, cal_q.gain_xy};
      REG_OFFSET_X: prdata = {12'd0, cal_q.offset_x};
      REG_GAIN_YX:  prdata = {8'd0, cal_q.gain_yx};
      REG_GAIN_YY:  prdata = {8'd0, cal_q.gain_yy};
      REG_OFFSET_Y: prdata = {12'd0, cal_q.offset_y};
      REG_INTERVAL: prdata = {24'd0, interval_q};
      default:      prdata = '0;
    endcase
  end

  assign full   = mid_full;
  assign accept = push && !full;

  tsc_front #(
    .SampleSlots(SAMPLE_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .pen_down_i(pen_down_i),
    .raw_x_i   (raw_x_i),
    .raw_y_i   (raw_y_i),
    .interval_i(interval_q),
    .tick_o    (front_tick)
  );

  tsc_fifo #(
    .Width($bits(tick_t)),
    .Depth(QueueDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(front_tick),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_tick),
    .empty_o(mid_empty)
  );

  tsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cal_i     (cal_q),
    .in_avail_i(!mid_empty),
    .tick_i    (mid_tick),
    .in_take_o (mid_pop),
    .out_full_i(out_full),
    .out_push_o(out_push),
    .result_o  (back_res)
  );

  tsc_fifo #(
    .Width($bits(result_t)),
    .Depth(QueueDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(back_res),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_res),
    .empty_o(empty)
  );

  assign mode_o         = out_res.mode;
  assign sample_valid_o = out_res.valid;
  assign sample_slot_o  = out_res.slot;
  assign point_x_o      = out_res.point_x;
  assign point_y_o      = out_res.point_y;

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !sample_valid_o) |->
      (sample_slot_o == 3'd0 && point_x_o == 10'd0 && point_y_o == 10'd0))
    else $error("word without a sample carries nonzero sample fields");

  a_sample_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sample_valid_o) |-> (mode_o != MODE_IDLE))
    else $error("sample reported with idle mode");

  a_back_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("back end pushed into a full result queue");

endmodule

### rtl/tsc_fifo.sv
// ----------------------------------------------------------------------------
// Touch sampler queue
// Small first-in first-out buffer for words between the sampler stages.
// ----------------------------------------------------------------------------
module tsc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// Touch sampler front end
// Tracks the touch mode, tick counter and slot, and marks ticks that sample.
// ----------------------------------------------------------------------------
module tsc_front #(
  parameter int unsigned SampleSlots = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          pen_down_i,
  input  logic [11:0]   raw_x_i,
  input  logic [11:0]   raw_y_i,
  input  logic [7:0]    interval_i,
  output tsc_pkg::tick_t tick_o
);

  import tsc_pkg::*;

  localparam int unsigned SlotW = $clog2(SampleSlots);

  typedef enum logic [1:0] {
    ST_IDLE     = MODE_IDLE,
    ST_PRE      = MODE_PRE,
    ST_TOUCHED  = MODE_TOUCHED,
    ST_RELEASED = MODE_RELEASED
  } state_e;

  state_e           state_q, state_d;
  logic [15:0]      cnt_q, cnt_d, cnt_inc, lim;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW+2:0] slot_ext;
  logic             take;

  assign cnt_inc  = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
  assign lim      = {8'd0, interval_i};
  assign slot_ext = {3'd0, slot_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_inc;
    slot_d  = slot_q;
    take    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pen_down_i) begin
          state_d = ST_PRE;
          cnt_d   = '0;
        end
      end
      ST_PRE, ST_TOUCHED: begin
        if (cnt_inc > lim) begin
          if (cnt_inc > lim + 16'd1) begin
            take  = 1'b1;
            cnt_d = '0;
            if (slot_q == SlotW'(SampleSlots - 1)) begin
              slot_d  = '0;
              state_d = ST_TOUCHED;
            end else begin
              slot_d = slot_q + 1'b1;
            end
          end
          if (!pen_down_i) begin
            state_d = ST_RELEASED;
          end
        end
      end
      ST_RELEASED: begin
        state_d = ST_IDLE;
        slot_d  = '0;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tick_o.mode  = state_d;
    tick_o.valid = take;
    tick_o.slot  = take ? slot_ext[2:0] : 3'd0;
    tick_o.raw_x = raw_x_i;
    tick_o.raw_y = raw_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      slot_q  <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
    end
  end

endmodule

### rtl/tsc_back.sv
// ----------------------------------------------------------------------------
// Touch sampler back end
// Maps raw readings to screen coordinates through the affine calibration.
// ----------------------------------------------------------------------------
module tsc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsc_pkg::cal_t     cal_i,
  input  logic              in_avail_i,
  input  tsc_pkg::tick_t    tick_i,
  output logic              in_take_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output tsc_pkg::result_t  result_o
);

  import tsc_pkg::*;

  logic                 st_valid_q;
  tick_t                st_tick_q;
  logic signed [36:0]   pxa_q, pxb_q, pya_q, pyb_q;
  logic signed [12:0]   rx, ry;
  logic signed [38:0]   acc_x, acc_y;
  logic                 advance;

  function automatic logic [9:0] sat_point(input logic signed [38:0] acc);
    logic [9:0] r;
    if (acc[38]) begin
      r = '0;
    end else if (|acc[37:30]) begin
      r = 10'h3FF;
    end else begin
      r = acc[29:20];
    end
    return r;
  endfunction

  assign rx        = $signed({1'b0, tick_i.raw_x});
  assign ry        = $signed({1'b0, tick_i.raw_y});
  assign advance   = !st_valid_q || !out_full_i;
  assign in_take_o = in_avail_i && advance;

  always_ff @(posedge clk_i) begin
    if (in_take_o) begin
      st_tick_q <= tick_i;
      pxa_q     <= cal_i.gain_xx * rx;
      pxb_q     <= cal_i.gain_xy * ry;
      pya_q     <= cal_i.gain_yx * rx;
      pyb_q     <= cal_i.gain_yy * ry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (advance) begin
      st_valid_q <= in_avail_i;
    end
  end

  assign acc_x = 39'(pxa_q) + 39'(pxb_q) + {{7{cal_i.offset_x[19]}}, cal_i.offset_x, 12'd0};
  assign acc_y = 39'(pya_q) + 39'(pyb_q) + {{7{cal_i.offset_y[19]}}, cal_i.offset_y, 12'd0};

  assign out_push_o = st_valid_q && !out_full_i;

  always_comb begin
    result_o.mode    = st_tick_q.mode;
    result_o.valid   = st_tick_q.valid;
    result_o.slot    = st_tick_q.slot;
    result_o.point_x = st_tick_q.valid ? sat_point(acc_x) : 10'd0;
    result_o.point_y = st_tick_q.valid ? sat_point(acc_y) : 10'd0;
  end

endmodule
